>>> hw/rtl/aip_pkg.sv
// aip_pkg: shared types, character codes and digit helpers of the ascii integer parser
// no dependencies; imported by aip_cfg, aip_core and ascii_integer_parser
package aip_pkg;

  localparam int VALUE_WIDTH_DEF = 16;
  localparam int INDEX_WIDTH_DEF = 16;
  localparam int RES_WIDTH       = 16;
  localparam int BASE_WIDTH      = 6;
  localparam int CHAR_WIDTH      = 8;
  localparam int DIGIT_WIDTH     = 7;
  localparam int APB_ADDR_WIDTH  = 3;
  localparam int APB_DATA_WIDTH  = 32;

  // register word index of the base register
  localparam logic REG_BASE_IDX = 1'b0;

  localparam logic [CHAR_WIDTH-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CHAR_WIDTH-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_WIDTH-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_WIDTH-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_WIDTH-1:0] LETTER_OFS = 8'd10;
  localparam logic [CHAR_WIDTH-1:0] DIGIT_NONE = 8'd99;

  localparam logic [BASE_WIDTH-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_WIDTH-1:0] BASE_MIN  = 6'd2;
  localparam logic [BASE_WIDTH-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_WIDTH-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_WIDTH-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_WIDTH-1:0] BASE_MAX  = 6'd36;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_POSTSIGN,
    PH_ZERO,
    PH_AFTERPFX,
    PH_DIGITS,
    PH_TRAIL,
    PH_FAILED
  } aip_phase_t;

  typedef struct packed {
    logic [RES_WIDTH-1:0] value;
    logic                 failed;
    logic [RES_WIDTH-1:0] stop_index;
  } aip_result_t;

  function automatic logic is_space(input logic [CHAR_WIDTH-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // digit value of 0-9, a-z, A-Z; 99 for anything else
  function automatic logic [DIGIT_WIDTH-1:0] digit_of(input logic [CHAR_WIDTH-1:0] c);
    logic [CHAR_WIDTH-1:0] t;
    t = DIGIT_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) t = c - CH_ZERO;
    else if (c >= CH_LO_A && c <= CH_LO_Z) t = c - CH_LO_A + LETTER_OFS;
    else if (c >= CH_UP_A && c <= CH_UP_Z) t = c - CH_UP_A + LETTER_OFS;
    return t[DIGIT_WIDTH-1:0];
  endfunction

endpackage

>>> hw/rtl/ascii_integer_parser.sv
// ascii_integer_parser: streaming string to integer converter, top level
// depends on aip_pkg, aip_cfg and aip_core
//
// input channel: one byte of a nul-terminated string per transaction on
// in_char_in (in_valid / in_ready); the 0 byte ends the string
// result channel: one transaction per string, issued for the 0 byte:
// out_value (signed, 0 on failure), out_failed, out_stop_index (index of the
// first offending character, 0 when out_failed is low)
// config: apb register 0 at byte address 0 holds the base (2..36, or 0 for
// c-style prefix detection); write it only while no string is in flight
// timing: one byte per cycle sustained; a byte sits one cycle in the input
// register while the parse state takes one multiply-add of the accumulator by
// the base; out_valid rises at the first edge after the 0 byte is accepted
// reset: rst_n (synchronous) clears the parse state and both valids, base to 0
// stall: while a result waits for out_ready, ordinary characters keep flowing;
// only a following 0 byte is held in the input register until the output
// register drains, and in_ready drops behind it
module ascii_integer_parser #(
  parameter int VALUE_WIDTH = aip_pkg::VALUE_WIDTH_DEF,
  parameter int INDEX_WIDTH = aip_pkg::INDEX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [aip_pkg::CHAR_WIDTH-1:0]     in_char_in,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [aip_pkg::RES_WIDTH-1:0] out_value,
  output logic                               out_failed,
  output logic [aip_pkg::RES_WIDTH-1:0]      out_stop_index,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [aip_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [aip_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [aip_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                               pready
);
  import aip_pkg::*;

  logic                  in_vld_r;
  logic [CHAR_WIDTH-1:0] char_r;
  logic                  out_vld_r;
  aip_result_t           res_r;
  aip_result_t           res;
  logic [BASE_WIDTH-1:0] base;
  logic                  is_end;
  logic                  consume;

  aip_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .base    (base)
  );

  aip_core #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (consume),
    .char_in (char_r),
    .base    (base),
    .result  (res)
  );

  // a terminator needs a free output slot, any other byte goes straight through
  assign is_end   = (char_r == CH_NUL);
  assign consume  = in_vld_r && (!is_end || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || consume;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) char_r <= in_char_in;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (consume && is_end) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && is_end) res_r <= res;
  end

  assign out_valid      = out_vld_r;
  assign out_value      = res_r.value;
  assign out_failed     = res_r.failed;
  assign out_stop_index = res_r.stop_index;

endmodule

>>> hw/rtl/aip_cfg.sv
// aip_cfg: apb register slave holding the number base register
// depends on aip_pkg
module aip_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [aip_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [aip_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [aip_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                               pready,
  output logic [aip_pkg::BASE_WIDTH-1:0]     base
);
  import aip_pkg::*;

  logic [BASE_WIDTH-1:0] base_r;
  logic                  sel_base;

  assign sel_base = (paddr[APB_ADDR_WIDTH-1] == REG_BASE_IDX);
  assign pready   = 1'b1;
  assign base     = base_r;

  always_comb begin
    prdata = '0;
    if (sel_base) prdata = {{(APB_DATA_WIDTH-BASE_WIDTH){1'b0}}, base_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_AUTO;
    end else if (psel && penable && pwrite && pready && sel_base) begin
      base_r <= pwdata[BASE_WIDTH-1:0];
    end
  end

endmodule

>>> hw/rtl/aip_core.sv
// aip_core: parse state registers and the one-character update logic
// depends on aip_pkg
module aip_core #(
  parameter int VALUE_WIDTH = aip_pkg::VALUE_WIDTH_DEF,
  parameter int INDEX_WIDTH = aip_pkg::INDEX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [aip_pkg::CHAR_WIDTH-1:0] char_in,
  input  logic [aip_pkg::BASE_WIDTH-1:0] base,
  output aip_pkg::aip_result_t           result
);
  import aip_pkg::*;

  aip_phase_t             ph_r, ph_nxt;
  logic                   neg_r, neg_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic [BASE_WIDTH-1:0]  ab_r, ab_nxt;
  logic [INDEX_WIDTH-1:0] cidx_r, cidx_nxt;
  logic [INDEX_WIDTH-1:0] fidx_r, fidx_nxt;
  logic                   fs_r, fs_nxt;

  logic                   sp;
  logic [DIGIT_WIDTH-1:0] dig;
  logic [VALUE_WIDTH-1:0] mag;
  logic [VALUE_WIDTH+RES_WIDTH-1:0] val_wide;
  logic [INDEX_WIDTH+RES_WIDTH-1:0] idx_wide;

  assign sp  = is_space(char_in);
  assign dig = digit_of(char_in);

  // next state for one character
  always_comb begin
    logic                              start;
    logic                              run_dig;
    logic                              fail;
    logic [BASE_WIDTH-1:0]             sb;
    logic [VALUE_WIDTH+BASE_WIDTH-1:0] prod;
    ph_nxt   = ph_r;
    neg_nxt  = neg_r;
    acc_nxt  = acc_r;
    ab_nxt   = ab_r;
    fidx_nxt = fidx_r;
    fs_nxt   = fs_r;
    start    = 1'b0;
    run_dig  = 1'b0;
    fail     = 1'b0;
    sb       = BASE_DEC;
    prod     = '0;
    unique case (ph_r)
      PH_LEAD: begin
        if (!sp) begin
          if (char_in == CH_MINUS || char_in == CH_PLUS) begin
            neg_nxt = (char_in == CH_MINUS);
            ph_nxt  = PH_POSTSIGN;
          end else begin
            start = 1'b1;
          end
        end
      end
      PH_POSTSIGN: begin
        if (!sp) start = 1'b1;
      end
      PH_ZERO: begin
        if (char_in == CH_LO_X || char_in == CH_UP_X) begin
          ab_nxt = BASE_HEX;
          ph_nxt = PH_AFTERPFX;
        end else begin
          run_dig = 1'b1;
        end
      end
      PH_AFTERPFX: begin
        if (char_in == CH_NUL) fail = 1'b1;
        else run_dig = 1'b1;
      end
      PH_DIGITS: begin
        run_dig = 1'b1;
      end
      PH_TRAIL: begin
        if (char_in != CH_NUL && !sp) fail = 1'b1;
      end
      PH_FAILED: begin
      end
      default: begin
      end
    endcase

    // first character of the number field
    if (start) begin
      if (base == BASE_AUTO && char_in == CH_ZERO) begin
        ab_nxt = BASE_OCT;
        ph_nxt = PH_ZERO;
      end else begin
        sb     = (base == BASE_AUTO) ? BASE_DEC : base;
        ab_nxt = sb;
        if (sb < BASE_MIN || sb > BASE_MAX || char_in == CH_NUL) fail = 1'b1;
        else run_dig = 1'b1;
      end
    end

    // digit accumulation, wraps modulo 2^VALUE_WIDTH
    if (run_dig) begin
      ph_nxt = PH_DIGITS;
      if (char_in != CH_NUL) begin
        if ({1'b0, ab_nxt} > dig) begin
          prod    = acc_r * ab_nxt;
          acc_nxt = prod[VALUE_WIDTH-1:0] + VALUE_WIDTH'(dig);
        end else if (sp) begin
          ph_nxt = PH_TRAIL;
        end else begin
          fail = 1'b1;
        end
      end
    end

    if (fail) begin
      ph_nxt = PH_FAILED;
      if (!fs_r) begin
        fs_nxt   = 1'b1;
        fidx_nxt = cidx_r;
      end
    end
  end

  assign cidx_nxt = (cidx_r == {INDEX_WIDTH{1'b1}}) ? cidx_r : cidx_r + 1'b1;

  // result fields, meaningful when the string terminator is processed
  always_comb begin
    mag      = neg_nxt ? (VALUE_WIDTH'(0) - acc_nxt) : acc_nxt;
    val_wide = {{RES_WIDTH{1'b0}}, mag};
    idx_wide = {{RES_WIDTH{1'b0}}, fidx_nxt};
    result.failed     = fs_nxt;
    result.value      = fs_nxt ? '0 : val_wide[RES_WIDTH-1:0];
    result.stop_index = fs_nxt ? idx_wide[RES_WIDTH-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_LEAD;
      neg_r  <= 1'b0;
      acc_r  <= '0;
      ab_r   <= '0;
      cidx_r <= '0;
      fidx_r <= '0;
      fs_r   <= 1'b0;
    end else if (step) begin
      if (char_in == CH_NUL) begin
        ph_r   <= PH_LEAD;
        neg_r  <= 1'b0;
        acc_r  <= '0;
        ab_r   <= '0;
        cidx_r <= '0;
        fidx_r <= '0;
        fs_r   <= 1'b0;
      end else begin
        ph_r   <= ph_nxt;
        neg_r  <= neg_nxt;
        acc_r  <= acc_nxt;
        ab_r   <= ab_nxt;
        cidx_r <= cidx_nxt;
        fidx_r <= fidx_nxt;
        fs_r   <= fs_nxt;
      end
    end
  end

endmodule
